[hw/rtl/xtea_pkg.sv]
`timescale 1ns / 1ps

package xtea_pkg;

    localparam logic [31:0] XT_DELTA   = 32'h9e37_79b9;
    localparam int          KEY_WORDS  = 4;
    localparam int          WORD_W     = 32;
    localparam int          KEY_IDX_W  = 2;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic              last;
    } t_block;

    // Feistel mixing of one half: ((v << 4) ^ (v >> 5)) + v
    function automatic logic [WORD_W-1:0] mix_half(input logic [WORD_W-1:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    // Running sum after n additions of delta, modulo 2^32
    function automatic logic [WORD_W-1:0] xt_sum(input int unsigned n);
        return WORD_W'(XT_DELTA * WORD_W'(n));
    endfunction

endpackage

[hw/rtl/xtea_in_if.sv]
`timescale 1ns / 1ps

interface xtea_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] word_first;
    logic [31:0] word_second;
    logic        last_in;

    modport source (output valid, output kind, output word_first, output word_second,
                    output last_in, input ready);
    modport sink   (input valid, input kind, input word_first, input word_second,
                    input last_in, output ready);
endinterface

[hw/rtl/xtea_out_if.sv]
`timescale 1ns / 1ps

interface xtea_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_first;
    logic [31:0] out_second;
    logic        last_out;

    modport source (output valid, output out_first, output out_second, output last_out,
                    input ready);
    modport sink   (input valid, input out_first, input out_second, input last_out,
                    output ready);
endinterface

[hw/rtl/xtea_cell.sv]
`timescale 1ns / 1ps

module xtea_cell #(
    parameter int STEP   = 0,
    parameter int CYCLES = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  xtea_pkg::t_key  i_key,
    input  logic            i_valid,
    input  xtea_pkg::t_block i_data,
    output logic            o_valid,
    output xtea_pkg::t_block o_data
);
    import xtea_pkg::*;

    // Half-round STEP of the enciphering order and of the deciphering order
    localparam int          ENC_N   = (STEP + 1) / 2;
    localparam int          DEC_N   = CYCLES - (STEP + 1) / 2;
    localparam logic        EVEN    = ((STEP % 2) == 0);
    localparam logic [WORD_W-1:0] ENC_SUM = xt_sum(ENC_N);
    localparam logic [WORD_W-1:0] DEC_SUM = xt_sum(DEC_N);
    // v0 updates take key[sum & 3], v1 updates take key[(sum >> 11) & 3]
    localparam logic [KEY_IDX_W-1:0] ENC_KEY = EVEN ? ENC_SUM[1:0] : ENC_SUM[12:11];
    localparam logic [KEY_IDX_W-1:0] DEC_KEY = EVEN ? DEC_SUM[12:11] : DEC_SUM[1:0];

    logic              r_valid;
    t_block            r_data;
    t_block            n_data;
    logic              w_upd_v0;
    logic [WORD_W-1:0] w_sum;
    logic [WORD_W-1:0] w_kw;
    logic [WORD_W-1:0] w_src;
    logic [WORD_W-1:0] w_dst;
    logic [WORD_W-1:0] w_f;
    logic [WORD_W-1:0] w_res;

    always_comb begin
        w_upd_v0 = EVEN ^ i_data.kind;
        w_sum    = i_data.kind ? DEC_SUM : ENC_SUM;
        w_kw     = i_data.kind ? i_key[DEC_KEY] : i_key[ENC_KEY];
        w_src    = w_upd_v0 ? i_data.v1 : i_data.v0;
        w_dst    = w_upd_v0 ? i_data.v0 : i_data.v1;
        w_f      = mix_half(w_src) ^ (w_sum + w_kw);
        w_res    = i_data.kind ? (w_dst - w_f) : (w_dst + w_f);
        n_data   = i_data;
        if (w_upd_v0) begin
            n_data.v0 = w_res;
        end else begin
            n_data.v1 = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hw/rtl/xtea_block_cipher.sv]
`timescale 1ns / 1ps
// Each input transaction passes through every cell of the chain, one registered half-round per cell.
// Throughput: one block per cycle while the output is not stalled; each cell performs one XTEA half-round.
// A stalled output holds the whole chain; the input is ready whenever the chain advances.
// Reset (synchronous, active low) empties the chain and clears all key words to zero.
module xtea_block_cipher #(
    parameter int CYCLES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    xtea_in_if.sink     i_blk,
    xtea_out_if.source  o_blk
);
    import xtea_pkg::*;

    localparam int NUM_CELLS = 2 * CYCLES;

    t_key                 r_key;
    logic                 w_adv;
    logic [NUM_CELLS-1:0] w_valid;
    t_block               w_data [NUM_CELLS];
    t_block               w_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Advance the whole chain unless the final cell holds an untaken result
    assign w_adv       = !w_valid[NUM_CELLS-1] || o_blk.ready;
    assign i_blk.ready = w_adv;

    always_comb begin
        w_in.kind = i_blk.kind;
        w_in.v0   = i_blk.word_first;
        w_in.v1   = i_blk.word_second;
        w_in.last = i_blk.last_in;
    end

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        if (c == 0) begin : g_head
            xtea_cell #(.STEP(c), .CYCLES(CYCLES)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_key   (r_key),
                .i_valid (i_blk.valid),
                .i_data  (w_in),
                .o_valid (w_valid[c]),
                .o_data  (w_data[c])
            );
        end else begin : g_body
            xtea_cell #(.STEP(c), .CYCLES(CYCLES)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_key   (r_key),
                .i_valid (w_valid[c-1]),
                .i_data  (w_data[c-1]),
                .o_valid (w_valid[c]),
                .o_data  (w_data[c])
            );
        end
    end

    assign o_blk.valid      = w_valid[NUM_CELLS-1];
    assign o_blk.out_first  = w_data[NUM_CELLS-1].v0;
    assign o_blk.out_second = w_data[NUM_CELLS-1].v1;
    assign o_blk.last_out   = w_data[NUM_CELLS-1].last;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_blk.valid && i_blk.ready) |=> w_valid[0])
        else $error("accepted block did not enter the first cell");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_valid))
        else $error("chain occupancy changed during a stall");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !i_blk.valid) |=> !w_valid[0])
        else $error("first cell became valid without an input transaction");

endmodule
